/* rtl/sskg_pkg.sv */
// ----------------------------------------------------------------------------
// sskg_pkg
// Shared constants, types and the gap table for the Knuth-gap Shell sorter.
// ----------------------------------------------------------------------------
package sskg_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int WORD_W       = 64;
  localparam int TOTAL_W      = 16;
  localparam int GAP_FACTOR   = 3;
  localparam int GAP_SLOTS    = 8;
  localparam int GAP_IDX_W    = $clog2(GAP_SLOTS);
  localparam int GAP_CNT_W    = $clog2(GAP_SLOTS + 1);
  localparam int GAP_W        = 16;

  // Read address source for the element store
  typedef enum logic [1:0] {
    RD_J    = 2'd0,
    RD_PREV = 2'd1,
    RD_K    = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;       // store or drop the incoming word
    logic    gap_init;   // pick the largest gap below the count, j = gap
    rd_sel_t rd_sel;     // store read address
    logic    take_held;  // held = read data, pos = j
    logic    cnt_inc;    // count one loop test
    logic    wr_shift;   // store[pos] = read data, pos -= gap
    logic    wr_held;    // store[pos] = held
    logic    j_inc;      // advance to the next element of this gap
    logic    gap_down;   // step to the next smaller gap, j = gap
    logic    emit;       // read store[k], advance k, strobe next cycle
    logic    clear;      // end of set: clear count, drop mark and test count
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic has_gap;     // some gap lies below the count
    logic pos_lt_gap;  // insertion position reached the front
    logic greater;     // store[pos - gap] > held, signed
    logic j_last;      // j is the last element
    logic gap_last;    // current gap is 1
    logic k_last;      // k is the last element
  } sts_t;

  // Knuth gap for a table slot: 1, 4, 13, 40, 121, ...
  function automatic logic [GAP_W-1:0] knuth_gap(input logic [GAP_IDX_W-1:0] idx);
    logic [GAP_W-1:0] g;
    g = GAP_W'(1);
    for (int i = 0; i < GAP_SLOTS - 1; i++) begin
      if (i < int'(idx)) begin
        g = GAP_W'(g * GAP_W'(GAP_FACTOR) + GAP_W'(1));
      end
    end
    return g;
  endfunction

endpackage

/* rtl/sskg_ram.sv */
// ----------------------------------------------------------------------------
// sskg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sskg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sskg_ctrl.sv */
// ----------------------------------------------------------------------------
// sskg_ctrl
// Sequencer for load, gapped insertion passes and result emission.
// ----------------------------------------------------------------------------
module sskg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            is_final,
  input  sskg_pkg::sts_t  sts,
  output sskg_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SETUP = 9'b000000010,
    S_JREAD = 9'b000000100,
    S_JWAIT = 9'b000001000,
    S_TEST  = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_GAPNX = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_DRAIN = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = sskg_pkg::RD_J;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (is_final) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.gap_init = 1'b1;
        state_next   = sts.has_gap ? S_JREAD : S_EMIT;
      end
      S_JREAD: begin
        cmd.rd_sel = sskg_pkg::RD_J;
        state_next = S_JWAIT;
      end
      S_JWAIT: begin
        cmd.take_held = 1'b1;
        state_next    = S_TEST;
      end
      S_TEST: begin
        cmd.cnt_inc = 1'b1;
        cmd.rd_sel  = sskg_pkg::RD_PREV;
        if (sts.pos_lt_gap) begin
          cmd.wr_held = 1'b1;
          cmd.j_inc   = 1'b1;
          state_next  = sts.j_last ? S_GAPNX : S_JREAD;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.wr_shift = 1'b1;
          state_next   = S_TEST;
        end else begin
          cmd.wr_held = 1'b1;
          cmd.j_inc   = 1'b1;
          state_next  = sts.j_last ? S_GAPNX : S_JREAD;
        end
      end
      S_GAPNX: begin
        if (sts.gap_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.gap_down = 1'b1;
          state_next   = S_JREAD;
        end
      end
      S_EMIT: begin
        cmd.rd_sel = sskg_pkg::RD_K;
        cmd.emit   = 1'b1;
        if (sts.k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sskg_dp.sv */
// ----------------------------------------------------------------------------
// sskg_dp
// Element store, indexes, gap selection, test counter and result registers.
// ----------------------------------------------------------------------------
module sskg_dp #(
  parameter int MAX_ELEMENTS = sskg_pkg::MAX_ELEMENTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sskg_pkg::cmd_t                   cmd,
  input  logic signed [sskg_pkg::WORD_W-1:0] element_value,
  output sskg_pkg::sts_t                   sts,
  output logic                             done,
  output logic signed [sskg_pkg::WORD_W-1:0] sorted_value,
  output logic [sskg_pkg::TOTAL_W-1:0]     comparison_total,
  output logic                             final_out,
  output logic                             overflow_flag
);

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int W      = sskg_pkg::WORD_W;
  localparam int GI_W   = sskg_pkg::GAP_IDX_W;

  logic [CNT_W-1:0]            count;
  logic                        dropped;
  logic [sskg_pkg::TOTAL_W-1:0] tests;
  logic [W-1:0]                held;
  logic [CNT_W-1:0]            pos;
  logic [CNT_W-1:0]            j;
  logic [CNT_W-1:0]            k;
  logic [GI_W-1:0]             gi;
  logic                        emit_v;
  logic                        emit_last;

  logic [sskg_pkg::GAP_CNT_W-1:0] ngaps;
  logic [GI_W-1:0]             gi_start;
  logic [GI_W-1:0]             gi_down;
  logic [CNT_W-1:0]            gap;
  logic [CNT_W-1:0]            gap_start;
  logic [CNT_W-1:0]            gap_lower;

  logic                        we;
  logic [ADDR_W-1:0]           waddr;
  logic [W-1:0]                wdata;
  logic [ADDR_W-1:0]           raddr;
  logic [W-1:0]                rdata;

  // Count the gaps below the set size
  always_comb begin
    ngaps = '0;
    for (int i = 0; i < sskg_pkg::GAP_SLOTS; i++) begin
      if (sskg_pkg::knuth_gap(GI_W'(i)) < sskg_pkg::GAP_W'(count)) begin
        ngaps = ngaps + 1'b1;
      end
    end
  end

  assign gi_start  = GI_W'(ngaps - 1'b1);
  assign gi_down   = gi - 1'b1;
  assign gap       = CNT_W'(sskg_pkg::knuth_gap(gi));
  assign gap_start = CNT_W'(sskg_pkg::knuth_gap(gi_start));
  assign gap_lower = CNT_W'(sskg_pkg::knuth_gap(gi_down));

  // Status to the controller
  always_comb begin
    sts.has_gap    = (ngaps != '0);
    sts.pos_lt_gap = (pos < gap);
    sts.greater    = ($signed(rdata) > $signed(held));
    sts.j_last     = (j + 1'b1 == count);
    sts.gap_last   = (gi == '0);
    sts.k_last     = (k + 1'b1 == count);
  end

  // Store port selection
  always_comb begin
    we    = 1'b0;
    waddr = pos[ADDR_W-1:0];
    wdata = held;
    if (cmd.load) begin
      we    = (count < CNT_W'(MAX_ELEMENTS));
      waddr = count[ADDR_W-1:0];
      wdata = element_value;
    end else if (cmd.wr_shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.wr_held) begin
      we    = 1'b1;
    end
    case (cmd.rd_sel)
      sskg_pkg::RD_J:    raddr = j[ADDR_W-1:0];
      sskg_pkg::RD_PREV: raddr = ADDR_W'(pos - gap);
      sskg_pkg::RD_K:    raddr = k[ADDR_W-1:0];
      default:           raddr = j[ADDR_W-1:0];
    endcase
  end

  sskg_ram #(
    .WIDTH (W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Set bookkeeping: fill count, drop mark, loop test count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count   <= '0;
      dropped <= 1'b0;
      tests   <= '0;
    end else begin
      if (cmd.load) begin
        if (count < CNT_W'(MAX_ELEMENTS)) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.cnt_inc && (tests != '1)) begin
        tests <= tests + 1'b1;
      end
    end
  end

  // Sort indexes and held word
  always_ff @(posedge clk) begin
    if (cmd.gap_init) begin
      gi <= gi_start;
      j  <= gap_start;
    end else if (cmd.gap_down) begin
      gi <= gi_down;
      j  <= gap_lower;
    end else if (cmd.j_inc) begin
      j <= j + 1'b1;
    end
    if (cmd.take_held) begin
      held <= rdata;
      pos  <= j;
    end else if (cmd.wr_shift) begin
      pos <= pos - gap;
    end
  end

  // Emission index and strobe
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      k         <= '0;
      emit_v    <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      emit_v    <= cmd.emit;
      emit_last <= cmd.emit && sts.k_last;
      if (cmd.emit) begin
        k <= k + 1'b1;
      end
    end
  end

  assign done             = emit_v;
  assign sorted_value     = rdata;
  assign comparison_total = tests;
  assign final_out        = emit_last;
  assign overflow_flag    = dropped;

endmodule

/* rtl/shell_sort_knuth_gaps_top.sv */
// ----------------------------------------------------------------------------
// shell_sort_knuth_gaps_top
// Loads a set of signed words, Shell sorts them with Knuth gaps, streams out.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  input    | start & !busy     | element_value, is_final
//  result   | done (1 cycle)    | sorted_value, comparison_total, final_out,
//           |                   | overflow_flag
//
// Words load at one per cycle while busy is low. After the final word the sort
// picks the largest gap below the set size, then per gap reads each element,
// holds it and shifts larger words up by the gap until it fits, each store
// read being registered. The results then follow back to back and the set
// clears with the last; busy is high from the final word to the last result.
// Reset (rst, synchronous) empties the set; the receiver cannot stall.
// ----------------------------------------------------------------------------
module shell_sort_knuth_gaps_top #(
  parameter int MAX_ELEMENTS = sskg_pkg::MAX_ELEMENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sskg_pkg::WORD_W-1:0] element_value,
  input  logic                               is_final,
  output logic                               done,
  output logic signed [sskg_pkg::WORD_W-1:0] sorted_value,
  output logic [sskg_pkg::TOTAL_W-1:0]       comparison_total,
  output logic                               final_out,
  output logic                               overflow_flag
);

  sskg_pkg::cmd_t cmd;
  sskg_pkg::sts_t sts;

  sskg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_final (is_final),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  sskg_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .element_value    (element_value),
    .sts              (sts),
    .done             (done),
    .sorted_value     (sorted_value),
    .comparison_total (comparison_total),
    .final_out        (final_out),
    .overflow_flag    (overflow_flag)
  );

endmodule

/* dv/shell_sort_knuth_gaps_sb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_sort_knuth_gaps_sb_pkg
// Scoreboard for the Knuth-gap Shell sorter: keeps its own copy of the set
// being loaded, sorts it on the final word while counting loop tests, and
// checks every streamed result against the oldest predicted word.
// ----------------------------------------------------------------------------
package shell_sort_knuth_gaps_sb_pkg;

  import sskg_pkg::*;

  // One predicted output word
  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic [TOTAL_W-1:0]       tests;
    logic                     last;
    logic                     dropped;
  } sorted_word_t;

  class sort_scoreboard;

    logic signed [WORD_W-1:0] set_words [MAX_ELEMENTS];
    int unsigned              set_fill;
    logic                     set_dropped;
    logic [TOTAL_W-1:0]       set_tests;
    sorted_word_t             pending_sorted [$];
    int unsigned              error_count;
    int unsigned              result_index;

    function new();
      set_fill     = 0;
      set_dropped  = 1'b0;
      set_tests    = '0;
      error_count  = 0;
      result_index = 0;
    endfunction

    function int unsigned outstanding();
      return pending_sorted.size();
    endfunction

    // Sort the loaded words in place, counting every loop test
    function void shell_sort_set();
      int unsigned gap;
      int unsigned j;
      int unsigned pos;
      logic signed [WORD_W-1:0] held;
      bit scanning;
      gap = 1;
      while (gap < set_fill) gap = GAP_FACTOR * gap + 1;
      gap = (gap - 1) / GAP_FACTOR;
      while (gap > 0) begin
        for (j = gap; j < set_fill; j++) begin
          held     = set_words[j];
          pos      = j;
          scanning = 1'b1;
          while (scanning) begin
            if (set_tests != '1) set_tests++;
            if (pos < gap || set_words[pos - gap] <= held) begin
              scanning = 1'b0;
            end else begin
              set_words[pos] = set_words[pos - gap];
              pos -= gap;
            end
          end
          set_words[pos] = held;
        end
        gap = (gap - 1) / GAP_FACTOR;
      end
    endfunction

    // Note one accepted input word; a final word releases the sorted set
    function void note_word(logic signed [WORD_W-1:0] value, logic is_last);
      sorted_word_t w;
      if (set_fill < MAX_ELEMENTS) begin
        set_words[set_fill] = value;
        set_fill++;
      end else begin
        set_dropped = 1'b1;
      end
      if (is_last) begin
        set_tests = '0;
        shell_sort_set();
        for (int k = 0; k < set_fill; k++) begin
          w.value   = set_words[k];
          w.tests   = set_tests;
          w.last    = (k + 1 == set_fill);
          w.dropped = set_dropped;
          pending_sorted.push_back(w);
        end
        set_fill    = 0;
        set_dropped = 1'b0;
        set_tests   = '0;
      end
    endfunction

    task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("ERROR result %0d: %s got %h expected %h", result_index, what, got, want);
      error_count++;
    endtask

    // Compare one streamed result with the oldest prediction
    task check_word(logic signed [WORD_W-1:0] value, logic [TOTAL_W-1:0] tests,
                    logic is_last, logic dropped);
      sorted_word_t w;
      if (pending_sorted.size() == 0) begin
        report_mismatch("unexpected result, value", value, '0);
      end else begin
        w = pending_sorted.pop_front();
        if (value !== w.value) report_mismatch("sorted_value", value, w.value);
        if (tests !== w.tests) report_mismatch("comparison_total", tests, w.tests);
        if (is_last !== w.last) report_mismatch("final_out", is_last, w.last);
        if (dropped !== w.dropped) report_mismatch("overflow_flag", dropped, w.dropped);
      end
      result_index++;
    endtask

  endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed words into the Knuth-gap Shell sorter, with directed
// edge sets first and random sets after, random gaps on the input side, and
// checks each streamed sorted word, test count and flags in order.
// ----------------------------------------------------------------------------
module testbench;

  import sskg_pkg::*;
  import shell_sort_knuth_gaps_sb_pkg::*;

  localparam int RANDOM_ITEMS  = 420;
  localparam int STALL_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RESET_CYCLES  = 12;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [WORD_W-1:0]   element_value = '0;
  logic                       is_final = 1'b0;
  logic                       done;
  logic signed [WORD_W-1:0]   sorted_value;
  logic [TOTAL_W-1:0]         comparison_total;
  logic                       final_out;
  logic                       overflow_flag;

  sort_scoreboard sort_board;
  int unsigned    items_sent = 0;
  int unsigned    stall_cycles = 0;
  bit             no_idle = 1'b0;

  shell_sort_knuth_gaps_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .element_value    (element_value),
    .is_final         (is_final),
    .done             (done),
    .sorted_value     (sorted_value),
    .comparison_total (comparison_total),
    .final_out        (final_out),
    .overflow_flag    (overflow_flag)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check every strobed result word
  always @(posedge clk) begin
    if (!rst && done) begin
      sort_board.check_word(sorted_value, comparison_total, final_out, overflow_flag);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("shell_sort_knuth_gaps_top verification failed");
      $finish;
    end
  end

  // Draw a value: mostly full range, some clustered, some extremes
  function automatic logic signed [WORD_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return {$urandom, $urandom};
    if (pick < 8) return WORD_W'($signed($urandom_range(0, 16)) - 8);
    if (pick < 9) return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
    return ($urandom_range(0, 1) != 0) ? '0 : '1;
  endfunction

  // Draw a set size: mostly small, a few full or past capacity
  function automatic int unsigned rand_set_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return $urandom_range(1, 10);
    if (pick < 17) return $urandom_range(11, 40);
    if (pick < 18) return MAX_ELEMENTS;
    if (pick < 19) return $urandom_range(MAX_ELEMENTS - 3, MAX_ELEMENTS - 1);
    return $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
  endfunction

  // Send one word: idle for a drawn gap, then hold it until accepted
  task automatic send_word(input logic signed [WORD_W-1:0] value, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    element_value <= value;
    is_final      <= last;
    do @(posedge clk); while (busy);
    sort_board.note_word(value, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a whole set, marking its last word
  task automatic send_set(input logic signed [WORD_W-1:0] words [$]);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  // Hold off until every predicted word has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (sort_board.outstanding() != 0);
  endtask

  initial begin
    logic signed [WORD_W-1:0] words [$];
    int unsigned set_no;
    int unsigned size;
    sort_board = new();

    // Hold reset, release at a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed sets: single words, extremes, duplicates, reversed, sorted
    words = '{WORD_MAX};
    send_set(words);
    words = '{WORD_MIN};
    send_set(words);
    words = '{WORD_MAX, WORD_MIN};
    send_set(words);
    words = '{WORD_MIN, WORD_MAX};
    send_set(words);
    words = '{-64'sd1, -64'sd1, -64'sd1};
    send_set(words);
    words = '{64'sd100, 64'sd0, -64'sd1, -64'sd100, WORD_MIN};
    send_set(words);
    words = '{WORD_MIN, -64'sd1, 64'sd0, WORD_MAX};
    send_set(words);
    words = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0001,
              64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555};
    send_set(words);
    drain_results();

    // Random sets: first one past capacity, then one exactly full
    set_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (set_no == 0) size = MAX_ELEMENTS + $urandom_range(1, 4);
      else if (set_no == 1) size = MAX_ELEMENTS;
      else size = rand_set_size();
      words.delete();
      repeat (size) words.push_back(rand_word());
      no_idle = ($urandom_range(0, 3) == 0);
      send_set(words);
      if ($urandom_range(0, 5) == 0) drain_results();
      set_no++;
    end

    // Wait out the last set, then a settle window for stray strobes
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sort_board.error_count == 0) begin
      $display("shell_sort_knuth_gaps_top verification clean");
    end else begin
      $display("shell_sort_knuth_gaps_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sskg_pkg.sv
rtl/sskg_ram.sv
rtl/sskg_ctrl.sv
rtl/sskg_dp.sv
rtl/shell_sort_knuth_gaps_top.sv
dv/shell_sort_knuth_gaps_sb_pkg.sv
dv/testbench.sv
